// File: rtl/core_delta_block_parser_macros.svh
// ----------------------------------------------------------------------------
// Core/delta block parser assertion macros
// Concurrent assertion wrappers; NO_ASSERTIONS leaves them empty.
// ----------------------------------------------------------------------------
`ifndef CORE_DELTA_BLOCK_PARSER_MACROS_SVH
`define CORE_DELTA_BLOCK_PARSER_MACROS_SVH

`ifndef NO_ASSERTIONS
// checked only out of reset
`define CDBP_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// checked at every edge, reset included
`define CDBP_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define CDBP_ASSERT(lbl, clk, rst_n, prop, msg)
`define CDBP_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

// File: rtl/cdbp_pkg.sv
// ----------------------------------------------------------------------------
// Core/delta block parser package
// Shared constants, register indexes and the result record.
// ----------------------------------------------------------------------------
package cdbp_pkg;

  localparam int CDBP_COORD_BITS = 14;   // default coordinate width
  localparam int CDBP_COORD_W    = 14;   // coordinate field width on the bus
  localparam int CDBP_QDEPTH     = 4;    // result queue entries
  localparam int CDBP_OUT_TDATA_W = 56;
  localparam int CDBP_CFG_W      = 2;

  // configuration register indexes
  localparam logic CFG_CORE_ANG  = 1'b0;
  localparam logic CFG_DELTA_ANG = 1'b1;

  typedef struct packed {
    logic                    point_valid;
    logic                    is_delta;
    logic [CDBP_COORD_W-1:0] x_coord;
    logic [CDBP_COORD_W-1:0] y_coord;
    logic                    has_angle;
    logic [7:0]              angle_first;
    logic [7:0]              angle_second;
    logic [7:0]              angle_third;
    logic                    block_last;
  } cdbp_rec_t;

  typedef struct packed {
    logic not_empty;
    logic full;
  } cdbp_qstat_t;

endpackage

// File: rtl/core_delta_block_parser.sv
// A result word is queued, then loaded into the output register that drives out_tvalid.
// Throughput: one byte per cycle while the queue is not full; each byte only steps the
// front-end parse state machine. Results drain one per cycle while out_tready is high,
// through a 4-entry queue and a registered output stage; input stalls only on a full queue.
// Reset: synchronous active-low rst_n; parser returns to the core-count phase, both
// angular codes to 1, queue and output register empty.
// ----------------------------------------------------------------------------
// Core/delta block parser top level
// Parses core/delta extended-data bytes into result words, one per point or end marker.
// ----------------------------------------------------------------------------
module core_delta_block_parser import cdbp_pkg::*; #(
  parameter int COORD_BITS = CDBP_COORD_BITS
) (
  input  logic                        clk,
  input  logic                        rst_n,
  // configuration
  input  logic                        cfg_we,
  input  logic                        cfg_index,
  input  logic [CDBP_CFG_W-1:0]       cfg_wdata,
  // byte stream in
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [7:0]                  in_tdata,   // data_byte
  input  logic                        in_tuser,   // block_start
  // result stream out
  output logic                        out_tvalid,
  input  logic                        out_tready,
  // x_coord[13:0], y_coord[27:14], has_angle[28], angle_first[36:29],
  // angle_second[44:37], angle_third[52:45], zero pad[55:53]
  output logic [CDBP_OUT_TDATA_W-1:0] out_tdata,
  output logic [1:0]                  out_tuser,  // point_valid[0], is_delta[1]
  output logic                        out_tlast   // block_last
);

  logic        in_fire, push, pop;
  cdbp_rec_t   push_rec, head_rec;
  cdbp_qstat_t qstat;

  assign in_tready = !qstat.full;
  assign in_fire   = in_tvalid && in_tready;

  cdbp_front #(.COORD_BITS(COORD_BITS)) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata),
    .in_fire     (in_fire),
    .data_byte   (in_tdata),
    .block_start (in_tuser),
    .push        (push),
    .rec         (push_rec)
  );

  cdbp_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_rec (push_rec),
    .pop      (pop),
    .head_rec (head_rec),
    .qstat    (qstat)
  );

  cdbp_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .qstat      (qstat),
    .head_rec   (head_rec),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

// File: rtl/cdbp_front.sv
// ----------------------------------------------------------------------------
// Core/delta block parser front end
// Byte-level parse state machine; assembles one record per finished point or end marker.
// ----------------------------------------------------------------------------
`include "core_delta_block_parser_macros.svh"

module cdbp_front import cdbp_pkg::*; #(
  parameter int COORD_BITS = CDBP_COORD_BITS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic                  cfg_index,
  input  logic [CDBP_CFG_W-1:0] cfg_wdata,
  input  logic                  in_fire,
  input  logic [7:0]            data_byte,
  input  logic                  block_start,
  output logic                  push,
  output cdbp_rec_t             rec
);

  typedef enum logic [9:0] {
    PH_CORE_COUNT  = 10'b00_0000_0001,
    PH_X_HI        = 10'b00_0000_0010,
    PH_X_LO        = 10'b00_0000_0100,
    PH_Y_HI        = 10'b00_0000_1000,
    PH_Y_LO        = 10'b00_0001_0000,
    PH_ANG1        = 10'b00_0010_0000,
    PH_ANG2        = 10'b00_0100_0000,
    PH_ANG3        = 10'b00_1000_0000,
    PH_DELTA_COUNT = 10'b01_0000_0000,
    PH_IDLE        = 10'b10_0000_0000
  } phase_t;

  phase_t                phase_r, phase_nxt, phase_eff;
  logic [5:0]            left_r, left_nxt, left_dec;
  logic                  delta_r, delta_nxt;
  logic                  flag_r, flag_nxt;
  logic [1:0]            core_code_r, delta_code_r;
  logic [5:0]            hi_r, hi_nxt;
  logic [COORD_BITS-1:0] x_r, x_nxt, y_r, y_nxt;
  logic [7:0]            a1_r, a1_nxt, a2_r, a2_nxt;
  logic [13:0]           word14;
  logic                  emit;
  logic [7:0]            e_a1, e_a2, e_a3;

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      core_code_r  <= 2'd1;
      delta_code_r <= 2'd1;
    end else if (cfg_we) begin
      if (cfg_index == CFG_CORE_ANG) core_code_r  <= cfg_wdata;
      else                           delta_code_r <= cfg_wdata;
    end
  end

  assign phase_eff = block_start ? PH_CORE_COUNT : phase_r;
  assign word14    = {hi_r, data_byte};
  assign left_dec  = left_r - 6'd1;

  always_comb begin
    phase_nxt = phase_r;
    left_nxt  = left_r;
    delta_nxt = delta_r;
    flag_nxt  = flag_r;
    hi_nxt    = hi_r;
    x_nxt     = x_r;
    y_nxt     = y_r;
    a1_nxt    = a1_r;
    a2_nxt    = a2_r;
    emit      = 1'b0;
    e_a1      = 8'd0;
    e_a2      = 8'd0;
    e_a3      = 8'd0;
    push      = 1'b0;
    rec       = '0;
    if (in_fire) begin
      case (phase_eff)
        PH_CORE_COUNT: begin
          delta_nxt = 1'b0;
          left_nxt  = data_byte[5:0];
          phase_nxt = (data_byte[5:0] != 6'd0) ? PH_X_HI : PH_DELTA_COUNT;
        end
        PH_DELTA_COUNT: begin
          delta_nxt = 1'b1;
          left_nxt  = data_byte[5:0];
          if (data_byte[5:0] != 6'd0) begin
            phase_nxt = PH_X_HI;
          end else begin
            // empty delta list: end marker only
            phase_nxt      = PH_IDLE;
            push           = 1'b1;
            rec.block_last = 1'b1;
          end
        end
        PH_X_HI: begin
          flag_nxt  = (data_byte[7:6] == (delta_r ? delta_code_r : core_code_r));
          hi_nxt    = data_byte[5:0];
          phase_nxt = PH_X_LO;
        end
        PH_X_LO: begin
          x_nxt     = word14[COORD_BITS-1:0];
          phase_nxt = PH_Y_HI;
        end
        PH_Y_HI: begin
          hi_nxt    = data_byte[5:0];
          phase_nxt = PH_Y_LO;
        end
        PH_Y_LO: begin
          y_nxt = word14[COORD_BITS-1:0];
          if (flag_r) phase_nxt = PH_ANG1;
          else        emit      = 1'b1;
        end
        PH_ANG1: begin
          if (!delta_r) begin
            emit = 1'b1;
            e_a1 = data_byte;
          end else begin
            a1_nxt    = data_byte;
            phase_nxt = PH_ANG2;
          end
        end
        PH_ANG2: begin
          a2_nxt    = data_byte;
          phase_nxt = PH_ANG3;
        end
        PH_ANG3: begin
          emit = 1'b1;
          e_a1 = a1_r;
          e_a2 = a2_r;
          e_a3 = data_byte;
        end
        default: phase_nxt = PH_IDLE;
      endcase

      if (emit) begin
        left_nxt = left_dec;
        if (left_dec != 6'd0) phase_nxt = PH_X_HI;
        else if (!delta_r)    phase_nxt = PH_DELTA_COUNT;
        else                  phase_nxt = PH_IDLE;
        push             = 1'b1;
        rec.point_valid  = 1'b1;
        rec.is_delta     = delta_r;
        rec.x_coord      = CDBP_COORD_W'(x_r);
        rec.y_coord      = CDBP_COORD_W'(y_nxt);
        rec.has_angle    = flag_r;
        rec.angle_first  = e_a1;
        rec.angle_second = e_a2;
        rec.angle_third  = e_a3;
        rec.block_last   = (left_dec == 6'd0) && delta_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_CORE_COUNT;
      left_r  <= 6'd0;
      delta_r <= 1'b0;
      flag_r  <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      left_r  <= left_nxt;
      delta_r <= delta_nxt;
      flag_r  <= flag_nxt;
    end
  end

  always_ff @(posedge clk) begin
    hi_r <= hi_nxt;
    x_r  <= x_nxt;
    y_r  <= y_nxt;
    a1_r <= a1_nxt;
    a2_r <= a2_nxt;
  end

  // a marker word always closes its block
  `CDBP_ASSERT(a_marker_last, clk, rst_n, (push && !rec.point_valid) |-> rec.block_last, "end marker without block_last")

endmodule

// File: rtl/cdbp_queue.sv
// ----------------------------------------------------------------------------
// Core/delta block parser result queue
// Small FIFO of result records between parse front end and output stage.
// ----------------------------------------------------------------------------
`include "core_delta_block_parser_macros.svh"

module cdbp_queue import cdbp_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  input  cdbp_rec_t   push_rec,
  input  logic        pop,
  output cdbp_rec_t   head_rec,
  output cdbp_qstat_t qstat
);

  localparam int PW = $clog2(CDBP_QDEPTH);
  localparam int CW = $clog2(CDBP_QDEPTH + 1);

  cdbp_rec_t       mem [CDBP_QDEPTH];
  logic [PW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [CW-1:0]   count_r;

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr_r] <= push_rec;
  end

  assign head_rec        = mem[rd_ptr_r];
  assign qstat.not_empty = (count_r != CW'(0));
  assign qstat.full      = (count_r == CW'(CDBP_QDEPTH));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push)
        wr_ptr_r <= (wr_ptr_r == PW'(CDBP_QDEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
      if (pop)
        rd_ptr_r <= (rd_ptr_r == PW'(CDBP_QDEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
      case ({push, pop})
        2'b10:   count_r <= count_r + CW'(1);
        2'b01:   count_r <= count_r - CW'(1);
        default: count_r <= count_r;
      endcase
    end
  end

  `CDBP_ASSERT(a_no_overflow, clk, rst_n, !(push && qstat.full), "push into full queue")
  `CDBP_ASSERT(a_no_underflow, clk, rst_n, !(pop && !qstat.not_empty), "pop from empty queue")
  `CDBP_ASSERT(a_count_step, clk, rst_n, (push && !pop) |=> (count_r == $past(count_r) + CW'(1)), "queue count lost a word")

endmodule

// File: rtl/cdbp_back.sv
// ----------------------------------------------------------------------------
// Core/delta block parser output stage
// Pulls records from the queue into the registered result channel.
// ----------------------------------------------------------------------------
module cdbp_back import cdbp_pkg::*; (
  input  logic                        clk,
  input  logic                        rst_n,
  input  cdbp_qstat_t                 qstat,
  input  cdbp_rec_t                   head_rec,
  output logic                        pop,
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [CDBP_OUT_TDATA_W-1:0] out_tdata,
  output logic [1:0]                  out_tuser,
  output logic                        out_tlast
);

  logic      valid_r;
  cdbp_rec_t rec_r;

  // refill whenever the register is empty or its word leaves this cycle
  assign pop = qstat.not_empty && (!valid_r || out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n)                 valid_r <= 1'b0;
    else if (pop)               valid_r <= 1'b1;
    else if (out_tready)        valid_r <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (pop) rec_r <= head_rec;
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = {3'b000, rec_r.angle_third, rec_r.angle_second, rec_r.angle_first,
                       rec_r.has_angle, rec_r.y_coord, rec_r.x_coord};
  assign out_tuser  = {rec_r.is_delta, rec_r.point_valid};
  assign out_tlast  = rec_r.block_last;

endmodule
